@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: payload structs,
// status and operation codes, and the sizes of the cell array.
// ----------------------------------------------------------------------------
package spq_pkg;

   // number of entries the cell array holds
   localparam int CAPACITY = 16;
   // bits of the held counter, wide enough to hold CAPACITY itself
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // request kinds as they arrive on the port
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_NULL  = 3'd1,
      ST_DUP   = 3'd2,
      ST_FULL  = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   // classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_REMOVE,
      OP_REJECT_NULL
   } op_type;

   typedef struct packed {
      logic               req_type;
      logic [31:0]        item_handle;
      logic [7:0]         entry_type;
      logic signed [15:0] entry_prio;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        out_handle;
      logic [7:0]         out_type;
      logic signed [15:0] out_prio;
      logic [4:0]         count;
   } rsp_item_type;

   // one stored entry
   typedef struct packed {
      logic [31:0]        handle;
      logic [7:0]         tag;
      logic signed [15:0] prio;
   } slot_type;

   typedef struct packed {
      op_type   op;
      slot_type slot;
   } cmd_type;

endpackage

@@ rtl/spq_front.sv @@
// ----------------------------------------------------------------------------
// spq_front
// Request front end: accepts requests, classifies them into insert, remove
// or null-handle reject, and holds them in a short command queue.
// ----------------------------------------------------------------------------
module spq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::req_item_type req_item,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output spq_pkg::cmd_type      cmd
);

   spq_pkg::cmd_type            queue_ff [spq_pkg::QDEPTH];
   logic [spq_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [spq_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [spq_pkg::QCNT_W-1:0]  fill_ff, fill_in;
   spq_pkg::cmd_type            cmd_new;
   logic                        push;
   logic                        pop;

   // classify the incoming request
   always_comb begin
      cmd_new.slot.handle = req_item.item_handle;
      cmd_new.slot.tag    = req_item.entry_type;
      cmd_new.slot.prio   = req_item.entry_prio;
      if (req_item.req_type == spq_pkg::REQ_REMOVE) begin
         cmd_new.op = spq_pkg::OP_REMOVE;
      end else if (req_item.item_handle == 32'd0) begin
         cmd_new.op = spq_pkg::OP_REJECT_NULL;
      end else begin
         cmd_new.op = spq_pkg::OP_INSERT;
      end
   end

   // queue control
   always_comb begin
      req_ready = (fill_ff != spq_pkg::QCNT_W'(spq_pkg::QDEPTH));
      cmd_valid = (fill_ff != '0);
      cmd       = queue_ff[rd_ptr_ff];
      push      = req_valid && req_ready;
      pop       = cmd_valid && cmd_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + spq_pkg::QCNT_W'(push) - spq_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ rtl/spq_back.sv @@
// ----------------------------------------------------------------------------
// spq_back
// Execution back end: a row of sorted cells that each compare against the
// broadcast command and shift in parallel, plus the result register.
// ----------------------------------------------------------------------------
module spq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  spq_pkg::cmd_type      cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spq_pkg::rsp_item_type rsp_item
);

   spq_pkg::slot_type           slot_ff [spq_pkg::CAPACITY];
   spq_pkg::slot_type           slot_ins [spq_pkg::CAPACITY];
   spq_pkg::slot_type           slot_rem [spq_pkg::CAPACITY];
   logic [spq_pkg::CNT_W-1:0]   held_ff, held_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_item_type       rsp_ff, rsp_in;
   logic [spq_pkg::CAPACITY-1:0] cell_valid;
   logic [spq_pkg::CAPACITY-1:0] cell_dup;
   logic [spq_pkg::CAPACITY-1:0] cell_le;
   logic                        take;
   logic                        do_insert;
   logic                        do_remove;
   logic                        is_dup;
   logic                        is_full;

   // per-cell compare and next value for insert and remove
   for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
      assign cell_valid[g] = (held_ff > spq_pkg::CNT_W'(g));
      assign cell_dup[g]   = cell_valid[g] && (slot_ff[g] == cmd.slot);
      assign cell_le[g]    = cell_valid[g] && (slot_ff[g].prio <= cmd.slot.prio);

      if (g == 0) begin : g_head
         assign slot_ins[g] = cell_le[g] ? slot_ff[g] : cmd.slot;
      end else begin : g_body
         assign slot_ins[g] = cell_le[g]     ? slot_ff[g] :
                              cell_le[g - 1] ? cmd.slot   : slot_ff[g - 1];
      end

      if (g == spq_pkg::CAPACITY - 1) begin : g_tail
         assign slot_rem[g] = slot_ff[g];
      end else begin : g_mid
         assign slot_rem[g] = slot_ff[g + 1];
      end
   end

   // command decode and result
   always_comb begin
      take         = cmd_valid && (!rsp_valid_ff || rsp_ready);
      cmd_ready    = !rsp_valid_ff || rsp_ready;
      is_dup       = |cell_dup;
      is_full      = (held_ff == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
      do_insert    = 1'b0;
      do_remove    = 1'b0;
      held_in      = held_ff;
      rsp_in       = '0;

      case (cmd.op)
         spq_pkg::OP_REJECT_NULL: begin
            rsp_in.status = spq_pkg::ST_NULL;
         end
         spq_pkg::OP_INSERT: begin
            if (is_dup) begin
               rsp_in.status = spq_pkg::ST_DUP;
            end else if (is_full) begin
               rsp_in.status = spq_pkg::ST_FULL;
            end else begin
               rsp_in.status = spq_pkg::ST_OK;
               do_insert     = take;
               held_in       = held_ff + spq_pkg::CNT_W'(1);
            end
         end
         spq_pkg::OP_REMOVE: begin
            if (held_ff == '0) begin
               rsp_in.status = spq_pkg::ST_EMPTY;
            end else begin
               rsp_in.status     = spq_pkg::ST_OK;
               rsp_in.out_handle = slot_ff[0].handle;
               rsp_in.out_type   = slot_ff[0].tag;
               rsp_in.out_prio   = slot_ff[0].prio;
               do_remove         = take;
               held_in           = held_ff - spq_pkg::CNT_W'(1);
            end
         end
         default: begin
            rsp_in.status = spq_pkg::ST_NULL;
         end
      endcase
      rsp_in.count = 5'(held_in);

      // result register: load on transfer in, drop on transfer out
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            held_ff <= held_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // cell array and result payload
   always_ff @(posedge clock) begin
      if (do_insert) begin
         slot_ff <= slot_ins;
      end else if (do_remove) begin
         slot_ff <= slot_rem;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ rtl/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue of (handle, type, priority) entries with stable
// ordering among equal priorities.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. Inserts are placed after every held
// entry of lower or equal priority value, so equal priorities leave in arrival
// order; an insert is rejected for a zero handle, an identical held entry or a
// full queue, in that order. A remove returns the head entry or an empty
// status. One request is executed per cycle while results are taken: the cell
// array compares every entry against the broadcast request and shifts in
// parallel, so the sustained rate is one request per cycle. A request transfer
// writes the command queue; the request then moves through the cell array into
// the result register once that register is free. The entry store needs no
// clearing after reset; only counts, queue pointers and result valid are reset.
module stable_priority_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spq_pkg::rsp_item_type rsp_item
);

   logic             cmd_valid;
   logic             cmd_ready;
   spq_pkg::cmd_type cmd;

   // request front end and command queue
   spq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // cell array and result register
   spq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty remove carries no entry and a zero count
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == spq_pkg::ST_EMPTY)
         |-> (rsp_item.count == 5'd0 && rsp_item.out_handle == 32'd0))
      else $error("empty result with entry or count");

   // rejected inserts carry no entry
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == spq_pkg::ST_NULL ||
                     rsp_item.status == spq_pkg::ST_DUP ||
                     rsp_item.status == spq_pkg::ST_FULL))
         |-> (rsp_item.out_handle == 32'd0 && rsp_item.out_prio == 16'sd0))
      else $error("rejected insert with entry fields");

   // command queue holds its head while the back end stalls
   a_cmd_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && !cmd_ready) |=> (cmd_valid && $stable(cmd)))
      else $error("command changed while stalled");

endmodule
